/* rtl/core/smzc_pkg.sv */
// Types, codes and constants shared by the change detector modules.
`default_nettype none

package smzc_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int LAG_W       = 7;
  localparam int THR_W       = 8;
  localparam int INFL_W      = 9;
  localparam int THR_SQ_W    = 2 * THR_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int BLEND_SHIFT = 8;
  localparam int LHS_SHIFT   = 8;

  localparam logic [LAG_W-1:0]    LAG_MIN      = 7'd2;
  localparam logic [LAG_W-1:0]    LAG_RESET    = 7'd10;
  localparam logic [THR_W-1:0]    THR_RESET    = 8'd48;
  localparam logic [INFL_W-1:0]   INFL_RESET   = 9'd128;
  // Unity weight in Q1.8.
  localparam logic [INFL_W-1:0]   INFL_ONE     = 9'd256;
  localparam logic [INFL_W-1:0]   ROUND_HALF   = 9'd128;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET =
    THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAG       = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_INFLUENCE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_e;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                   changed;
    logic [SAMPLE_BITS-1:0] level;
    logic                   filling;
  } out_item_t;

  typedef struct packed {
    logic [LAG_W-1:0]    lag_eff;
    logic [THR_SQ_W-1:0] thr_sq;
    logic [INFL_W-1:0]   infl_eff;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_VAR,
    ST_THR,
    ST_CMP,
    ST_PUSH,
    ST_EMIT
  } smzc_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_FILL,
    OP_DROP,
    OP_MUL,
    OP_VAR,
    OP_THR,
    OP_CMP,
    OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic filling;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/smzc_cfg.sv */
// Configuration registers with their clamped and squared forms.
`default_nettype none

module smzc_cfg import smzc_pkg::*; #(
  parameter int MAX_LAG = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_i,
  input  wire logic [CFG_IDX_W-1:0]  index_i,
  input  wire logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                       cfg_o
);

  logic [LAG_W-1:0]    lag_q;
  logic [THR_SQ_W-1:0] thr_sq_q;
  logic [INFL_W-1:0]   infl_q;

  // The threshold is only ever used squared, so the square is stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q    <= LAG_RESET;
      thr_sq_q <= THR_SQ_RESET;
      infl_q   <= INFL_RESET;
    end else if (wr_i) begin
      unique case (index_i)
        CFG_LAG:       lag_q    <= data_i[LAG_W-1:0];
        CFG_THRESHOLD: thr_sq_q <= THR_SQ_W'(data_i[THR_W-1:0]) *
                                   THR_SQ_W'(data_i[THR_W-1:0]);
        CFG_INFLUENCE: infl_q   <= data_i[INFL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lag_q < LAG_MIN) begin
      cfg_o.lag_eff = LAG_MIN;
    end else if (32'(lag_q) > MAX_LAG) begin
      cfg_o.lag_eff = LAG_W'(MAX_LAG);
    end else begin
      cfg_o.lag_eff = lag_q;
    end
    cfg_o.thr_sq   = thr_sq_q;
    cfg_o.infl_eff = (infl_q > INFL_ONE) ? INFL_ONE : infl_q;
  end

endmodule

`default_nettype wire

/* rtl/core/smzc_ctrl.sv */
// Controller state machine that sequences the datapath and owns the input and output handshakes.
`default_nettype none

module smzc_ctrl import smzc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  smzc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.is_clear) begin
          cmd_o.op = OP_CLEAR;
          state_d  = ST_EMIT;
        end else if (sts_i.filling) begin
          cmd_o.op = OP_FILL;
          state_d  = ST_PUSH;
        end else begin
          cmd_o.op = OP_DROP;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_VAR;
      end
      ST_VAR: begin
        cmd_o.op = OP_VAR;
        state_d  = ST_THR;
      end
      ST_THR: begin
        cmd_o.op = OP_THR;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = OP_CMP;
        state_d  = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DECIDE)
    else $error("accepted item did not move to the decision step");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_q || out_ready_i)
    else $error("result loaded over an item not yet taken");

  a_push_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_PUSH |=> state_q == ST_EMIT)
    else $error("window update not followed by result delivery");

endmodule

`default_nettype wire

/* rtl/core/smzc_dp.sv */
// Datapath: window memory, running sums and the chained multiply and compare.
`default_nettype none

module smzc_dp import smzc_pkg::*; #(
  parameter int MAX_LAG = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire in_item_t in_data_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_sts_t       sts_o,
  output out_item_t     out_data_o
);

  localparam int CW = $clog2(MAX_LAG + 1);
  localparam int PW = $clog2(MAX_LAG);
  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + CW;
  localparam int QW = 2 * SB + CW;
  localparam int DW = SB + CW;
  localparam int VW = 2 * DW;
  localparam int VL = VW / 2;
  localparam int VH = VW - VL;
  localparam int TW = THR_SQ_W;
  localparam int RW = VW + TW;
  localparam int BW = SB + INFL_W + 1;

  logic [SB-1:0]     mem_q [MAX_LAG];
  logic [SB-1:0]     rdata_q;
  logic [SB-1:0]     x_q;
  logic              func_q;
  logic [PW-1:0]     wp_q;
  logic [CW-1:0]     count_q;
  logic [SW-1:0]     sum_q;
  logic [QW-1:0]     sqsum_q;
  logic [SB-1:0]     newest_q;
  logic [DW-1:0]     nx_q;
  logic [2*SB-1:0]   xsq_q;
  logic [SB-1:0]     blend_q;
  logic [VW-1:0]     dsq_q;
  logic [VW-1:0]     ssq_q;
  logic [VW-1:0]     nq_q;
  logic [VW-1:0]     var_q;
  logic [VL+TW-1:0]  plo_q;
  logic [VH+TW-1:0]  phi_q;
  logic [SB-1:0]     push_val_q;
  logic [2*SB-1:0]   push_sq_q;
  out_item_t         res_q;
  out_item_t         out_q;

  logic [CW:0]       wp_ext, cnt_ext, ridx;
  logic [PW-1:0]     raddr;
  logic [PW-1:0]     wp_next;
  logic [CW-1:0]     cnt_dec;
  logic [2*SB-1:0]   old_sq, x_sq, blend_sq;
  logic [DW-1:0]     dev;
  logic [BW-1:0]     blend_sum;
  logic [RW-1:0]     lhs, rhs;
  logic              pass;

  // The oldest entry sits count places behind the write pointer.
  always_comb begin
    wp_ext  = (CW+1)'(wp_q);
    cnt_ext = (CW+1)'(count_q);
    if (wp_ext >= cnt_ext) begin
      ridx = wp_ext - cnt_ext;
    end else begin
      ridx = wp_ext + (CW+1)'(MAX_LAG) - cnt_ext;
    end
  end
  assign raddr = ridx[PW-1:0];

  assign wp_next  = (wp_q == PW'(MAX_LAG - 1)) ? '0 : wp_q + PW'(1);
  assign cnt_dec  = count_q - CW'(1);
  assign old_sq   = (2*SB)'(rdata_q) * (2*SB)'(rdata_q);
  assign x_sq     = (2*SB)'(x_q) * (2*SB)'(x_q);
  assign blend_sq = (2*SB)'(blend_q) * (2*SB)'(blend_q);
  assign dev      = (nx_q >= sum_q) ? nx_q - sum_q : sum_q - nx_q;

  assign blend_sum = BW'(cfg_i.infl_eff) * BW'(x_q)
                   + BW'(INFL_ONE - cfg_i.infl_eff) * BW'(newest_q)
                   + BW'(ROUND_HALF);

  // Scaled squared deviation against threshold squared times n*Q - S^2.
  assign lhs  = RW'({dsq_q, {LHS_SHIFT{1'b0}}});
  assign rhs  = {phi_q, {VL{1'b0}}} + RW'(plo_q);
  assign pass = (lhs <= rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      sqsum_q  <= '0;
      newest_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_CLEAR: begin
          wp_q    <= '0;
          count_q <= '0;
          sum_q   <= '0;
          sqsum_q <= '0;
        end
        OP_DROP: begin
          count_q <= cnt_dec;
          sum_q   <= sum_q - SW'(rdata_q);
          sqsum_q <= sqsum_q - QW'(old_sq);
        end
        OP_PUSH: begin
          wp_q     <= wp_next;
          count_q  <= count_q + CW'(1);
          sum_q    <= sum_q + SW'(push_val_q);
          sqsum_q  <= sqsum_q + QW'(push_sq_q);
          newest_q <= push_val_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q     <= in_data_i.sample;
        func_q  <= in_data_i.func;
        rdata_q <= mem_q[raddr];
      end
      OP_CLEAR: begin
        res_q.changed <= 1'b0;
        res_q.level   <= '0;
        res_q.filling <= 1'b1;
      end
      OP_FILL: begin
        push_val_q    <= x_q;
        push_sq_q     <= x_sq;
        res_q.changed <= 1'b0;
        res_q.level   <= x_q;
        res_q.filling <= 1'b1;
      end
      OP_DROP: begin
        nx_q    <= DW'(cnt_dec) * DW'(x_q);
        xsq_q   <= x_sq;
        blend_q <= SB'(blend_sum >> BLEND_SHIFT);
      end
      OP_MUL: begin
        dsq_q <= VW'(dev) * VW'(dev);
        ssq_q <= VW'(sum_q) * VW'(sum_q);
        nq_q  <= VW'(count_q) * VW'(sqsum_q);
      end
      OP_VAR: begin
        var_q <= nq_q - ssq_q;
      end
      OP_THR: begin
        plo_q <= (VL+TW)'(cfg_i.thr_sq) * (VL+TW)'(var_q[VL-1:0]);
        phi_q <= (VH+TW)'(cfg_i.thr_sq) * (VH+TW)'(var_q[VW-1:VL]);
      end
      OP_CMP: begin
        push_val_q    <= pass ? x_q : blend_q;
        push_sq_q     <= pass ? xsq_q : blend_sq;
        res_q.changed <= !pass;
        res_q.level   <= x_q;
        res_q.filling <= 1'b0;
      end
      OP_PUSH: begin
        mem_q[wp_q] <= push_val_q;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.is_clear = (func_q == FUNC_CLEAR);
  assign sts_o.filling  = (32'(count_q) < 32'(cfg_i.lag_eff));
  assign out_data_o     = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_LAG)
    else $error("window fill count beyond the memory depth");

  a_pointer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < MAX_LAG)
    else $error("write pointer outside the window memory");

  a_spread_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_VAR |-> nq_q >= ssq_q)
    else $error("running sums give a negative spread");

endmodule

`default_nettype wire

/* rtl/core/smoothed_zscore_change_detector.sv */
// Top level of the smoothed z-score change detector for light samples.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i   (func, sample)
//   out     | output    | out_valid_o / out_ready_i| out_data_o  (changed, level, filling)
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sample that meets a full window passes the decide, multiply, variance, threshold,
// compare, push and emit steps before its result is valid, and the next item is taken
// only once the block is back in idle. A sample that fills the window passes the decide,
// push and emit steps, and a clear item only the decide and emit steps.
// Reset empties the window and loads the register defaults; no clearing pass runs.
// The output register lets a new item enter while a result still waits; a stalled
// output holds the block in its final step until the result is taken.
`default_nettype none

module smoothed_zscore_change_detector import smzc_pkg::*; #(
  parameter int MAX_LAG = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  smzc_cfg #(
    .MAX_LAG (MAX_LAG)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  smzc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smzc_dp #(
    .MAX_LAG (MAX_LAG)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
